// ===== hdl/ckp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckp_pkg
// widths, register codes and pipeline payload types for the keep-out projection
// ----------------------------------------------------------------------------
package ckp_pkg;

	localparam int CW    = 16;              // coordinate width
	localparam int RW    = CW - 1;          // radius width
	localparam int AW    = CW + 1;          // delta width
	localparam int G     = 33 - CW;         // guard fraction bits of the distance
	localparam int DW    = 2 * RW;          // squared distance once inside
	localparam int RADW  = 2 * (RW + G);    // square root radicand
	localparam int ROOTW = RW + G;          // square root result
	localparam int NUMW  = 2 * RW + G;      // divide numerator
	localparam int NRW   = NUMW + 1;        // numerator plus rounding term
	localparam int QW    = CW;              // quotient width

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic                 sx;
		logic                 sy;
		logic                 in_circle;
		logic                 zero;
		logic [NUMW-1:0]      numx;
		logic [NUMW-1:0]      numy;
	} side_t;

endpackage

// ===== hdl/circle_keepout_projection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_keepout_projection
// pushes points inside a keep-out circle radially onto its edge
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: point_x, point_y
// m_axis    out  m_axis_tvalid/tready       tdata: out_x, out_y; tuser: was_inside
// apb       in   psel/penable/pwrite        paddr, pwdata, prdata (3 registers)
//
// one item per cycle unless m_axis_tready stalls the pipe; the pipe holds 32 root stages
// (one result bit each), one rounding stage and 16 divide stages (one quotient bit each)
// arst_n clears the valid bits and the registers; payload flops are not reset
// each stage holds while its successor is full and stalled, bubbles close up
// ----------------------------------------------------------------------------
module circle_keepout_projection (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // point_x [15:0], point_y [31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // out_x [15:0], out_y [31:16]
	output logic        m_axis_tuser,   // was_inside [0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW    = ckp_pkg::CW;
	localparam int RW    = ckp_pkg::RW;
	localparam int AW    = ckp_pkg::AW;
	localparam int G     = ckp_pkg::G;
	localparam int DW    = ckp_pkg::DW;
	localparam int RADW  = ckp_pkg::RADW;
	localparam int ROOTW = ckp_pkg::ROOTW;
	localparam int NRW   = ckp_pkg::NRW;
	localparam int QW    = ckp_pkg::QW;

	// stage numbering along the pipe
	localparam int S_SQ0 = 4;
	localparam int S_RND = S_SQ0 + ROOTW;
	localparam int S_DV0 = S_RND + 1;
	localparam int S_OUT = S_DV0 + QW;
	localparam int NS    = S_OUT;

	// ---------------- configuration registers ----------------
	logic signed [CW-1:0] center_x_q;
	logic signed [CW-1:0] center_y_q;
	logic [RW-1:0]        radius_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				ckp_pkg::REG_CENTER_X: center_x_q <= pwdata[CW-1:0];
				ckp_pkg::REG_CENTER_Y: center_y_q <= pwdata[CW-1:0];
				ckp_pkg::REG_RADIUS:   radius_q   <= pwdata[RW-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ckp_pkg::REG_CENTER_X: prdata = {{(32-CW){center_x_q[CW-1]}}, center_x_q};
			ckp_pkg::REG_CENTER_Y: prdata = {{(32-CW){center_y_q[CW-1]}}, center_y_q};
			ckp_pkg::REG_RADIUS:   prdata = {{(32-RW){1'b0}}, radius_q};
			default:               prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// a stage loads when it is empty or its successor loads
	logic [NS:1]   vld_q;
	logic [NS+1:1] ld;

	assign ld[NS+1] = m_axis_tready;
	genvar gi;
	generate
		for (gi = 1; gi <= NS; gi++) begin : g_ld
			assign ld[gi] = !vld_q[gi] || ld[gi+1];
		end
	endgenerate

	assign s_axis_tready = ld[1];
	assign m_axis_tvalid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) vld_q[1] <= s_axis_tvalid;
			for (int i = 2; i <= NS; i++) begin
				if (ld[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// ---------------- stage 1: offsets from the center ----------------
	logic signed [CW-1:0] in_x, in_y;
	logic signed [CW-1:0] px_s1, py_s1;
	logic signed [AW-1:0] dx_s1, dy_s1;

	assign in_x = s_axis_tdata[CW-1:0];
	assign in_y = s_axis_tdata[2*CW-1:CW];

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			px_s1 <= in_x;
			py_s1 <= in_y;
			dx_s1 <= {in_x[CW-1], in_x} - {center_x_q[CW-1], center_x_q};
			dy_s1 <= {in_y[CW-1], in_y} - {center_y_q[CW-1], center_y_q};
		end
	end

	// ---------------- stage 2: magnitudes, box test, products ----------------
	logic [AW-1:0]        ax, ay;
	logic signed [CW-1:0] px_s2, py_s2;
	logic                 sx_s2, sy_s2, box_s2;
	logic [DW-1:0]        sqx_s2, sqy_s2, rr_s2, mx_s2, my_s2;

	assign ax = dx_s1[AW-1] ? (~dx_s1 + 1'b1) : dx_s1;
	assign ay = dy_s1[AW-1] ? (~dy_s1 + 1'b1) : dy_s1;

	// products only matter once the box test passes, so the low bits suffice
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			sx_s2  <= dx_s1[AW-1];
			sy_s2  <= dy_s1[AW-1];
			box_s2 <= (ax <= {2'b00, radius_q}) && (ay <= {2'b00, radius_q});
			sqx_s2 <= ax[RW-1:0] * ax[RW-1:0];
			sqy_s2 <= ay[RW-1:0] * ay[RW-1:0];
			rr_s2  <= radius_q * radius_q;
			mx_s2  <= ax[RW-1:0] * radius_q;
			my_s2  <= ay[RW-1:0] * radius_q;
		end
	end

	// ---------------- stage 3: squared distance and inside test ----------------
	logic [DW:0]       d2;
	ckp_pkg::side_t    side_s3;
	logic [RADW-1:0]   rad_s3;

	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			side_s3.px        <= px_s2;
			side_s3.py        <= py_s2;
			side_s3.sx        <= sx_s2;
			side_s3.sy        <= sy_s2;
			side_s3.in_circle <= box_s2 && (d2 <= {1'b0, rr_s2});
			side_s3.zero      <= (d2 == '0);
			side_s3.numx      <= {mx_s2, {G{1'b0}}};
			side_s3.numy      <= {my_s2, {G{1'b0}}};
			rad_s3            <= {d2[DW-1:0], {(2*G){1'b0}}};
		end
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [RADW-1:0] sqx_s  [ROOTW];   // running remainder
	logic [RADW-1:0] sqr_s  [ROOTW];   // partial root
	ckp_pkg::side_t  sqsd_s [ROOTW];

	generate
		for (gi = 0; gi < ROOTW; gi++) begin : g_sqrt
			localparam logic [RADW-1:0] BIT = {{(RADW-1){1'b0}}, 1'b1} << (RADW - 2 - 2*gi);
			logic [RADW-1:0] x_in, r_in, trial;
			ckp_pkg::side_t  sd_in;
			if (gi == 0) begin : g_first
				assign x_in  = rad_s3;
				assign r_in  = '0;
				assign sd_in = side_s3;
			end else begin : g_next
				assign x_in  = sqx_s[gi-1];
				assign r_in  = sqr_s[gi-1];
				assign sd_in = sqsd_s[gi-1];
			end
			assign trial = r_in + BIT;
			always_ff @(posedge clk) begin
				if (ld[S_SQ0+gi]) begin
					sqsd_s[gi] <= sd_in;
					if (x_in >= trial) begin
						sqx_s[gi] <= x_in - trial;
						sqr_s[gi] <= (r_in >> 1) + BIT;
					end else begin
						sqx_s[gi] <= x_in;
						sqr_s[gi] <= r_in >> 1;
					end
				end
			end
		end
	endgenerate

	// ---------------- rounding: numerator plus half the distance ----------------
	logic [ROOTW-1:0] root;
	logic [NRW-1:0]   nrx_rnd, nry_rnd;
	logic [ROOTW-1:0] den_rnd;
	ckp_pkg::side_t   side_rnd;

	assign root = sqr_s[ROOTW-1][ROOTW-1:0];

	always_ff @(posedge clk) begin
		if (ld[S_RND]) begin
			side_rnd <= sqsd_s[ROOTW-1];
			den_rnd  <= root;
			nrx_rnd  <= {1'b0, sqsd_s[ROOTW-1].numx} + NRW'(root >> 1);
			nry_rnd  <= {1'b0, sqsd_s[ROOTW-1].numy} + NRW'(root >> 1);
		end
	end

	// ---------------- divide, one quotient bit per stage ----------------
	logic [NRW-1:0]   dvrx_s [QW];
	logic [NRW-1:0]   dvry_s [QW];
	logic [QW-1:0]    dvqx_s [QW];
	logic [QW-1:0]    dvqy_s [QW];
	logic [ROOTW-1:0] dvdn_s [QW];
	ckp_pkg::side_t   dvsd_s [QW];

	generate
		for (gi = 0; gi < QW; gi++) begin : g_div
			localparam int SH = QW - 1 - gi;
			logic [NRW-1:0]   rx_in, ry_in, dsh;
			logic [QW-1:0]    qx_in, qy_in;
			logic [ROOTW-1:0] dn_in;
			ckp_pkg::side_t   sd_in;
			if (gi == 0) begin : g_first
				assign rx_in = nrx_rnd;
				assign ry_in = nry_rnd;
				assign qx_in = '0;
				assign qy_in = '0;
				assign dn_in = den_rnd;
				assign sd_in = side_rnd;
			end else begin : g_next
				assign rx_in = dvrx_s[gi-1];
				assign ry_in = dvry_s[gi-1];
				assign qx_in = dvqx_s[gi-1];
				assign qy_in = dvqy_s[gi-1];
				assign dn_in = dvdn_s[gi-1];
				assign sd_in = dvsd_s[gi-1];
			end
			assign dsh = {{(NRW-ROOTW){1'b0}}, dn_in} << SH;
			always_ff @(posedge clk) begin
				if (ld[S_DV0+gi]) begin
					dvdn_s[gi] <= dn_in;
					dvsd_s[gi] <= sd_in;
					if (rx_in >= dsh) begin
						dvrx_s[gi] <= rx_in - dsh;
						dvqx_s[gi] <= qx_in | (QW'(1) << SH);
					end else begin
						dvrx_s[gi] <= rx_in;
						dvqx_s[gi] <= qx_in;
					end
					if (ry_in >= dsh) begin
						dvry_s[gi] <= ry_in - dsh;
						dvqy_s[gi] <= qy_in | (QW'(1) << SH);
					end else begin
						dvry_s[gi] <= ry_in;
						dvqy_s[gi] <= qy_in;
					end
				end
			end
		end
	endgenerate

	// ---------------- output: sign, add center, saturate, or pass through ----------------
	function automatic logic signed [CW-1:0] place(
		input logic signed [CW-1:0] c,
		input logic [QW-1:0]        q,
		input logic                 neg
	);
		logic signed [AW-1:0] off;
		logic signed [AW:0]   sum;
		off = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		sum = {{2{c[CW-1]}}, c} + {off[AW-1], off};
		if (sum > $signed({2'b00, {(CW-1){1'b1}}}))
			place = {1'b0, {(CW-1){1'b1}}};
		else if (sum < $signed({2'b11, 1'b1, {(CW-1){1'b0}}}))
			place = {1'b1, {(CW-1){1'b0}}};
		else
			place = sum[CW-1:0];
		return place;
	endfunction

	ckp_pkg::side_t       sd_last;
	logic signed [CW-1:0] ox_s, oy_s;
	logic                 ins_s;

	assign sd_last = dvsd_s[QW-1];

	always_ff @(posedge clk) begin
		if (ld[S_OUT]) begin
			ins_s <= sd_last.in_circle;
			if (!sd_last.in_circle) begin
				ox_s <= sd_last.px;
				oy_s <= sd_last.py;
			end else if (sd_last.zero) begin
				// on the center: no direction, answer is the center
				ox_s <= center_x_q;
				oy_s <= center_y_q;
			end else begin
				ox_s <= place(center_x_q, dvqx_s[QW-1], sd_last.sx);
				oy_s <= place(center_y_q, dvqy_s[QW-1], sd_last.sy);
			end
		end
	end

	assign m_axis_tdata = {oy_s, ox_s};
	assign m_axis_tuser = ins_s;

`ifndef ASSERT_OFF
	// an empty first stage always takes an item
	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> s_axis_tready)
		else $error("input stalled with empty first stage");

	// root remainder stays within twice the root
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_RND-1] && sqsd_s[ROOTW-1].in_circle |->
			sqx_s[ROOTW-1] <= (sqr_s[ROOTW-1] << 1))
		else $error("square root remainder out of range");

	// divide remainder below divisor at the end
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_OUT-1] && sd_last.in_circle && !sd_last.zero |->
			dvrx_s[QW-1] < {{(NRW-ROOTW){1'b0}}, dvdn_s[QW-1]} &&
			dvry_s[QW-1] < {{(NRW-ROOTW){1'b0}}, dvdn_s[QW-1]})
		else $error("divide remainder not below divisor");

	// offset never exceeds the radius by more than one step
	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_OUT-1] && sd_last.in_circle && !sd_last.zero |->
			{1'b0, dvqx_s[QW-1]} <= {2'b00, radius_q} + 1'b1 &&
			{1'b0, dvqy_s[QW-1]} <= {2'b00, radius_q} + 1'b1)
		else $error("projected offset beyond radius");
`endif

endmodule
